FILE: rtl/slcd_pkg.sv
// Shared constants, types and codes for the SLIP length and checksum deframer.
package slcd_pkg;

    // Default for the largest payload a frame may carry.
    localparam int MAX_PAYLOAD_DEF = 256;

    // SLIP symbols.
    localparam logic [7:0] SYM_FLAG     = 8'hC0;
    localparam logic [7:0] SYM_ESC      = 8'hDB;
    localparam logic [7:0] SYM_ESC_FLAG = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC  = 8'hDD;

    // Receiver phase within a frame.
    typedef enum logic [1:0] {
        ST_LEN_HI,
        ST_LEN_LO,
        ST_BODY,
        ST_IGNORE
    } rx_state_t;

    // Frame completion status codes.
    typedef enum logic [1:0] {
        STAT_NONE,
        STAT_BAD_ESC,
        STAT_BAD_LEN,
        STAT_CSUM
    } status_t;

    // One byte handed from the input register to the decoder.
    typedef struct packed {
        logic       fire;
        logic [7:0] data;
    } in_xfer_t;

    // One result item.
    typedef struct packed {
        logic       frame_start;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       frame_good;
        logic [8:0] payload_length;
        status_t    status;
    } result_t;

endpackage

FILE: rtl/slip_length_checksum_deframer_top.sv
// Top level of the SLIP deframer with length field and checksum.
//
// Takes one received byte per transfer and returns exactly one result per byte. The block
// sustains one byte per clock cycle while the output is not stalled: a byte sits in the input
// register, is decoded against the frame state while it moves into the output register, and
// is presented from there. The frame state (phase, escape, length, running sum, payload
// position) updates once per byte in that single decode step. A frame opens with the 0xC0
// flag, carries a two-byte big-endian length that counts payload plus checksum, then the
// payload bytes with their index, then a checksum byte that makes the 8-bit sum of the
// length bytes, payload and checksum zero. A bad escape, a zero length or a length above
// MAX_PAYLOAD + 1 ends the frame with an error status, and bytes after any frame end are
// dropped with an empty result until the next flag.
module slip_length_checksum_deframer_top #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_start,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic       frame_done,
    output logic       frame_good,
    output logic [8:0] payload_length,
    output logic [1:0] status
);
    import slcd_pkg::*;

    in_xfer_t xfer;
    result_t  result;
    result_t  out_result;
    logic     advance;

    slcd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .xfer     (xfer)
    );

    slcd_decode #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .xfer   (xfer),
        .result (result)
    );

    slcd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (xfer.fire),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // Unpack the held result onto the ports.
    assign frame_start    = out_result.frame_start;
    assign payload_valid  = out_result.payload_valid;
    assign payload_byte   = out_result.payload_byte;
    assign payload_index  = out_result.payload_index;
    assign frame_done     = out_result.frame_done;
    assign frame_good     = out_result.frame_good;
    assign payload_length = out_result.payload_length;
    assign status         = out_result.status;

endmodule

FILE: rtl/slcd_in_stage.sv
// Input register that holds one received byte until the decoder takes it.
module slcd_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 advance,
    output slcd_pkg::in_xfer_t   xfer
);
    import slcd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // The register can take a new transfer when it is empty or when its content moves on.
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    // The held byte is decoded in the cycle it advances.
    assign xfer.fire = valid_reg && advance;
    assign xfer.data = byte_reg;

endmodule

FILE: rtl/slcd_decode.sv
// Frame decoder: unstuffing, length check, payload indexing and checksum state.
module slcd_decode #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  slcd_pkg::in_xfer_t  xfer,
    output slcd_pkg::result_t   result
);
    import slcd_pkg::*;

    // Payload positions run up to MAX_PAYLOAD.
    localparam int          IDX_W     = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] LEN_LIMIT = 17'(MAX_PAYLOAD + 1);

    rx_state_t          state_reg, state_next;
    logic               esc_reg, esc_next;
    logic [7:0]         len_hi_reg, len_hi_next;
    logic [7:0]         sum_reg, sum_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   plen_reg, plen_next;

    logic [7:0]         ub;
    logic               have_byte;
    logic [15:0]        len_word;
    logic [7:0]         csum;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LEN_HI;
            esc_reg    <= 1'b0;
            len_hi_reg <= '0;
            sum_reg    <= '0;
            idx_reg    <= '0;
            plen_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            esc_reg    <= esc_next;
            len_hi_reg <= len_hi_next;
            sum_reg    <= sum_next;
            idx_reg    <= idx_next;
            plen_reg   <= plen_next;
        end
    end

    // Next state and result for the byte being decoded.
    always_comb
    begin
        state_next  = state_reg;
        esc_next    = esc_reg;
        len_hi_next = len_hi_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        plen_next   = plen_reg;
        result      = '0;
        ub          = xfer.data;
        have_byte   = 1'b0;
        len_word    = {len_hi_reg, xfer.data};
        csum        = sum_reg + xfer.data;

        if (xfer.fire)
        begin
            if (xfer.data == SYM_FLAG)
            begin
                // A flag always starts a fresh frame, dropping any partial one.
                result.frame_start = 1'b1;
                state_next         = ST_LEN_HI;
                esc_next           = 1'b0;
                len_hi_next        = '0;
                sum_next           = '0;
                idx_next           = '0;
                plen_next          = '0;
            end
            else if (state_reg != ST_IGNORE)
            begin
                // Undo byte stuffing.
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (xfer.data == SYM_ESC_FLAG)
                    begin
                        ub        = SYM_FLAG;
                        have_byte = 1'b1;
                    end
                    else if (xfer.data == SYM_ESC_ESC)
                    begin
                        ub        = SYM_ESC;
                        have_byte = 1'b1;
                    end
                    else
                    begin
                        result.frame_done = 1'b1;
                        result.status     = STAT_BAD_ESC;
                        state_next        = ST_IGNORE;
                    end
                end
                else if (xfer.data == SYM_ESC)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    have_byte = 1'b1;
                end

                len_word = {len_hi_reg, ub};
                csum     = sum_reg + ub;

                // Place the unstuffed byte within the frame.
                if (have_byte)
                begin
                    unique case (state_reg)
                        ST_LEN_HI:
                        begin
                            len_hi_next = ub;
                            sum_next    = csum;
                            state_next  = ST_LEN_LO;
                        end
                        ST_LEN_LO:
                        begin
                            sum_next = csum;
                            if (len_word == 16'd0 || {1'b0, len_word} > LEN_LIMIT)
                            begin
                                result.frame_done = 1'b1;
                                result.status     = STAT_BAD_LEN;
                                state_next        = ST_IGNORE;
                            end
                            else
                            begin
                                plen_next  = IDX_W'(len_word - 16'd1);
                                idx_next   = '0;
                                state_next = ST_BODY;
                            end
                        end
                        ST_BODY:
                        begin
                            if (idx_reg < plen_reg)
                            begin
                                result.payload_valid = 1'b1;
                                result.payload_byte  = ub;
                                result.payload_index = 8'(idx_reg);
                                sum_next             = csum;
                                idx_next             = idx_reg + 1'b1;
                            end
                            else
                            begin
                                // Checksum byte: the total over the frame must be zero.
                                result.frame_done     = 1'b1;
                                result.frame_good     = (csum == 8'd0);
                                result.payload_length = 9'(plen_reg);
                                result.status         = (csum == 8'd0) ? STAT_NONE : STAT_CSUM;
                                state_next            = ST_IGNORE;
                            end
                        end
                        ST_IGNORE:
                        begin
                            state_next = ST_IGNORE;
                        end
                    endcase
                end
            end
        end
    end

    // A flag never ends a frame or carries payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_start |-> !result.frame_done && !result.payload_valid)
        else $error("flag byte produced frame end or payload");

    // Every frame end leaves the receiver dropping bytes until a flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_done |=> state_reg == ST_IGNORE)
        else $error("receiver not idle after frame end");

    // A flag restarts the length phase with no escape pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_start |=> state_reg == ST_LEN_HI && !esc_reg && sum_reg == 8'd0)
        else $error("flag did not restart the frame");

    // Each payload byte advances the position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.payload_valid |=> idx_reg == IDX_W'($past(idx_reg) + 1'b1))
        else $error("payload index did not advance");

endmodule

FILE: rtl/slcd_out_stage.sv
// Output register that holds one result until the receiver takes it.
module slcd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  slcd_pkg::result_t  result,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_stall,
    output slcd_pkg::result_t  out_result
);
    import slcd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // The register takes a new result when empty or when its result leaves.
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
        begin
            data_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

FILE: tb/tb_slip_length_checksum_deframer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SLIP deframer with length field and checksum.
module tb_slip_length_checksum_deframer_top;
    import slcd_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int STUCK_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 1500;
    localparam int BUSY_PCT     = 32;
    localparam int MAX_PRINTS   = 100;

    // One step of the directed table; typed rows carry their own expected result.
    typedef struct {
        logic [7:0] rx;
        bit         typed;
        result_t    res;
    } dir_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       frame_start;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_good;
    logic [8:0] payload_length;
    logic [1:0] status;

    // Deframer state as this testbench tracks it.
    logic [8:0] rx_count  = '0;
    logic [8:0] rx_total  = '0;
    logic [7:0] len_msb   = '0;
    logic [7:0] frame_sum = '0;
    logic       esc_seen  = 1'b0;
    logic       hunting   = 1'b0;

    result_t    awaited_results[$];
    dir_row_t   dir_rows[$];
    logic [7:0] line_q[$];
    bit         want_typed = 1'b0;
    result_t    want_res   = '0;
    int         gap_pct    = BUSY_PCT;
    int         errors     = 0;
    int         result_no  = 0;
    int         stuck      = 0;

    slip_length_checksum_deframer_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_start   (frame_start),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_done    (frame_done),
        .frame_good    (frame_good),
        .payload_length(payload_length),
        .status        (status)
    );

    always #(CLK_HALF) clk = ~clk;

    // The result side stalls at random, and not at all during the quiet stretch.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < gap_pct);
    end

    // Ends a frame: a result with frame_done set, then drop bytes until the next flag.
    function automatic result_t close_frame(input logic good, input logic [8:0] plen,
                                           input status_t st);
        result_t r;
        r                = '0;
        r.frame_done     = 1'b1;
        r.frame_good     = good;
        r.payload_length = plen;
        r.status         = st;
        hunting          = 1'b1;
        esc_seen         = 1'b0;
        return r;
    endfunction

    // Works out the result of one received byte and advances the frame state.
    function automatic result_t deframe_byte(input logic [7:0] raw);
        result_t    r;
        logic [7:0] b;
        logic [7:0] total_sum;
        logic [8:0] pos;
        int         len;
        r = '0;
        b = raw;
        if (raw == SYM_FLAG)
        begin
            rx_count      = '0;
            rx_total      = '0;
            len_msb       = '0;
            frame_sum     = '0;
            esc_seen      = 1'b0;
            hunting       = 1'b0;
            r.frame_start = 1'b1;
            return r;
        end
        if (hunting)
            return r;
        // Undo byte stuffing; anything but the two legal codes after an escape is fatal.
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b == SYM_ESC_FLAG)
                b = SYM_FLAG;
            else if (b == SYM_ESC_ESC)
                b = SYM_ESC;
            else
                return close_frame(1'b0, '0, STAT_BAD_ESC);
        end
        else if (b == SYM_ESC)
        begin
            esc_seen = 1'b1;
            return r;
        end
        if (rx_count == 9'd0)
        begin
            len_msb   = b;
            frame_sum = frame_sum + b;
            rx_count  = 9'd1;
        end
        else if (rx_count == 9'd1)
        begin
            len       = int'({len_msb, b});
            frame_sum = frame_sum + b;
            if (len == 0 || len - 1 > MAX_PAYLOAD)
                return close_frame(1'b0, '0, STAT_BAD_LEN);
            rx_total = len[8:0];
            rx_count = 9'd2;
        end
        else
        begin
            pos = rx_count - 9'd2;
            if (pos < rx_total - 9'd1)
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = pos[7:0];
                frame_sum       = frame_sum + b;
                rx_count        = rx_count + 9'd1;
            end
            else
            begin
                // Checksum byte: the 8-bit sum over the whole frame must come to zero.
                total_sum = frame_sum + b;
                if (total_sum == 8'h00)
                    return close_frame(1'b1, rx_total - 9'd1, STAT_NONE);
                return close_frame(1'b0, rx_total - 9'd1, STAT_CSUM);
            end
        end
        return r;
    endfunction

    function automatic result_t outcome(input logic start, input logic done, input logic good,
                                        input logic [8:0] plen, input status_t st);
        result_t r;
        r                = '0;
        r.frame_start    = start;
        r.frame_done     = done;
        r.frame_good     = good;
        r.payload_length = plen;
        r.status         = st;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] rx, input bit typed, input result_t res);
        dir_row_t entry;
        entry.rx    = rx;
        entry.typed = typed;
        entry.res   = res;
        dir_rows.push_back(entry);
    endfunction

    // Payload content leans on the SLIP symbols and the byte extremes.
    function automatic logic [7:0] pick_data();
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return SYM_FLAG;
            1: return SYM_ESC;
            2: return SYM_ESC_FLAG;
            3: return SYM_ESC_ESC;
            4: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic void put_stuffed(input logic [7:0] b);
        if (b == SYM_FLAG)
        begin
            line_q.push_back(SYM_ESC);
            line_q.push_back(SYM_ESC_FLAG);
        end
        else if (b == SYM_ESC)
        begin
            line_q.push_back(SYM_ESC);
            line_q.push_back(SYM_ESC_ESC);
        end
        else
            line_q.push_back(b);
    endfunction

    // Queues one frame on the line and returns how many of its bytes the block acts on.
    // Mostly good frames; the rest carry a bad checksum, a bad length, a bad escape,
    // are cut short by the next flag, or are plain noise.
    function automatic int build_frame(input bit force_max);
        int         kind;
        int         plen;
        int         total;
        int         cut;
        int         start;
        int         counted;
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] bad;
        kind  = force_max ? 0 : $urandom_range(99);
        start = line_q.size();
        line_q.push_back(SYM_FLAG);
        if ($urandom_range(19) == 0)
            line_q.push_back(SYM_FLAG);
        if (kind >= 95)
        begin
            repeat ($urandom_range(1, 8))
                line_q.push_back(8'($urandom_range(255)));
            return line_q.size() - start;
        end
        // Small frames keep the run short; a few reach the largest payload.
        if (force_max)
            plen = MAX_PAYLOAD;
        else if ($urandom_range(29) == 0)
            plen = $urandom_range(MAX_PAYLOAD - 40, MAX_PAYLOAD);
        else
            plen = $urandom_range(0, 12);
        total = plen + 1;
        if (kind >= 80 && kind < 85)
            total = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_PAYLOAD + 2, 65535);
        body.push_back(total[15:8]);
        body.push_back(total[7:0]);
        if (kind < 80 || kind >= 85)
        begin
            repeat (plen)
                body.push_back(pick_data());
            sum = '0;
            foreach (body[i])
                sum = sum + body[i];
            sum = -sum;
            if (kind >= 70)
                sum = sum + 8'($urandom_range(1, 255));
            body.push_back(sum);
        end
        cut = body.size();
        if (kind >= 85)
            cut = $urandom_range(0, body.size() - 1);
        for (int i = 0; i < cut; i++)
            put_stuffed(body[i]);
        if (kind >= 85 && kind < 90)
        begin
            if ($urandom_range(3) == 0)
                bad = SYM_ESC;
            else
            begin
                do
                    bad = 8'($urandom_range(255));
                while (bad == SYM_ESC_FLAG || bad == SYM_ESC_ESC || bad == SYM_FLAG);
            end
            line_q.push_back(SYM_ESC);
            line_q.push_back(bad);
        end
        counted = line_q.size() - start;
        // Bytes after a frame has ended are dropped, so they do not count.
        if (kind < 90 && $urandom_range(2) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                do
                    bad = 8'($urandom_range(255));
                while (bad == SYM_FLAG);
                line_q.push_back(bad);
            end
        end
        return counted;
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0d ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want)
            report($sformatf("result %0d %s got %0h want %0h", result_no, name, got, want));
    endtask

    // Drives one byte from a falling edge and holds it until the transfer is taken.
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t res);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        want_typed = typed;
        want_res   = res;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Holds off the sender until every awaited result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Predicts on each input transfer, checks each output transfer, and guards against hangs.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = deframe_byte(rx_byte);
                if (want_typed)
                    want = want_res;
                awaited_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                result_no++;
                if (awaited_results.size() == 0)
                    report($sformatf("result %0d arrived with nothing awaited", result_no));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("frame_start", 9'(frame_start), 9'(want.frame_start));
                    check_field("payload_valid", 9'(payload_valid), 9'(want.payload_valid));
                    check_field("payload_byte", 9'(payload_byte), 9'(want.payload_byte));
                    check_field("payload_index", 9'(payload_index), 9'(want.payload_index));
                    check_field("frame_done", 9'(frame_done), 9'(want.frame_done));
                    check_field("frame_good", 9'(frame_good), 9'(want.frame_good));
                    check_field("payload_length", payload_length, want.payload_length);
                    check_field("status", 9'(status), 9'(want.status));
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
            begin
                stuck++;
                if (stuck >= STUCK_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Main stimulus sequence.
    initial
    begin : stimulus
        int sent;
        int frames;
        bit drained;
        sent    = 0;
        frames  = 0;
        drained = 1'b0;

        // Out of reset the block takes bytes as if a flag had just come: zero length.
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b1, outcome(1'b0, 1'b1, 1'b0, 9'd0, STAT_BAD_LEN));
        // Dropped until the next flag.
        add_row(8'hFF, 1'b1, outcome(1'b0, 1'b0, 1'b0, 9'd0, STAT_NONE));
        // A length of 0x0102 is one payload byte too long.
        add_row(SYM_FLAG, 1'b1, outcome(1'b1, 1'b0, 1'b0, 9'd0, STAT_NONE));
        add_row(8'h01, 1'b0, '0);
        add_row(8'h02, 1'b1, outcome(1'b0, 1'b1, 1'b0, 9'd0, STAT_BAD_LEN));
        // Two escaped payload bytes, a matching checksum, then a dropped byte.
        add_row(SYM_FLAG, 1'b1, outcome(1'b1, 1'b0, 1'b0, 9'd0, STAT_NONE));
        add_row(8'h00, 1'b0, '0);
        add_row(8'h03, 1'b0, '0);
        add_row(SYM_ESC, 1'b0, '0);
        add_row(SYM_ESC_FLAG, 1'b0, '0);
        add_row(SYM_ESC, 1'b0, '0);
        add_row(SYM_ESC_ESC, 1'b0, '0);
        add_row(8'h62, 1'b1, outcome(1'b0, 1'b1, 1'b1, 9'd2, STAT_NONE));
        add_row(8'h55, 1'b1, outcome(1'b0, 1'b0, 1'b0, 9'd0, STAT_NONE));
        // Largest legal length, cut short by a flag that also clears a pending escape.
        add_row(SYM_FLAG, 1'b1, outcome(1'b1, 1'b0, 1'b0, 9'd0, STAT_NONE));
        add_row(8'h01, 1'b0, '0);
        add_row(8'h01, 1'b0, '0);
        add_row(SYM_ESC, 1'b0, '0);
        add_row(SYM_FLAG, 1'b1, outcome(1'b1, 1'b0, 1'b0, 9'd0, STAT_NONE));
        // One payload byte with a wrong checksum.
        add_row(8'h00, 1'b0, '0);
        add_row(8'h02, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b1, outcome(1'b0, 1'b1, 1'b0, 9'd1, STAT_CSUM));
        // An escape followed by another escape.
        add_row(SYM_FLAG, 1'b1, outcome(1'b1, 1'b0, 1'b0, 9'd0, STAT_NONE));
        add_row(SYM_ESC, 1'b0, '0);
        add_row(SYM_ESC, 1'b1, outcome(1'b0, 1'b1, 1'b0, 9'd0, STAT_BAD_ESC));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // Random frames; the first one carries the largest payload.
        while (sent < RANDOM_BYTES)
        begin
            sent += build_frame(frames == 0);
            frames++;
            gap_pct = (sent > 500 && sent < 900) ? 0 : BUSY_PCT;
            while (line_q.size() != 0)
                send_byte(line_q.pop_front(), 1'b0, '0);
            if (!drained && sent > 1000)
            begin
                drain_results();
                drained = 1'b1;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
